>>> rtl/core/tfs_pkg.sv
// shared types, constants and helpers for the transmitter fault supervisor
// no dependencies; every other file of the block imports this package

package tfs_pkg;

    // fixed field widths
    localparam int NUM_FAULTS   = 9;
    localparam int PULSE_BIT    = 4;
    localparam int ACTION_W     = 2;
    localparam int TIME_W       = 31;
    localparam int READ_IDX_W   = 4;
    localparam int READ_COUNT_W = 16;
    localparam int READ_TIME_W  = 32;
    localparam int PHASE_W      = 2;
    localparam int WINDOW_W     = 16;
    localparam int RECENT_W     = 8;
    localparam int TRIES_W      = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // parameter defaults
    localparam int HISTORY_DEPTH_DEF = 10;
    localparam int COUNT_WIDTH_DEF   = 16;

    // register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_RST    = WINDOW_W'(100);
    localparam logic [RECENT_W-1:0] RECENT_RST    = RECENT_W'(2);
    localparam logic [TRIES_W-1:0]  MAX_TRIES_RST = TRIES_W'(10);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECENT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES = 2'd2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_POLL         = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MANUAL_RESET = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ         = 2'd2;

    // read index of the auto reset counter
    localparam logic [READ_IDX_W-1:0] AUTO_READ_INDEX = READ_IDX_W'(NUM_FAULTS);

    // reported recovery phase codes
    localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_CLEAR   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_OPERATE = 2'd2;

    // recovery state machine
    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_CLEAR   = 3'b010,
        PH_OPERATE = 3'b100
    } t_phase;

    // one accepted input item
    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [NUM_FAULTS-1:0] fault_flags;
        logic                  fault_any;
        logic                  hv_runup;
        logic [TIME_W-1:0]     now_seconds;
        logic [READ_IDX_W-1:0] read_index;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic                     send_fault_reset;
        logic                     send_operate;
        logic                     auto_reset_enabled;
        logic [PHASE_W-1:0]       recovery_phase;
        logic                     recovery_failed;
        logic [NUM_FAULTS-1:0]    new_fault_flags;
        logic [READ_COUNT_W-1:0]  read_count;
        logic signed [READ_TIME_W-1:0] read_time;
    } t_result;

    // request into the fault statistics
    typedef struct packed {
        logic                  update;
        logic [NUM_FAULTS-1:0] flags;
        logic [TIME_W-1:0]     now;
        logic [READ_IDX_W-1:0] read_index;
    } t_stats_req;

    // answer from the fault statistics
    typedef struct packed {
        logic [NUM_FAULTS-1:0]   rose;
        logic [READ_COUNT_W-1:0] count;
        logic [READ_TIME_W-1:0]  last_time;
    } t_stats_rsp;

    // reported code of a recovery state
    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_IDLE:    code = PHASE_CODE_IDLE;
            PH_CLEAR:   code = PHASE_CODE_CLEAR;
            PH_OPERATE: code = PHASE_CODE_OPERATE;
            default:    code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/core/tfs_if.sv
// channel interfaces of the transmitter fault supervisor: status input,
// result output and configuration write; depends on tfs_pkg

interface tfs_in_if import tfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [NUM_FAULTS-1:0] fault_flags;
    logic                  fault_any;
    logic                  hv_runup;
    logic [TIME_W-1:0]     now_seconds;
    logic [READ_IDX_W-1:0] read_index;

    modport source (output valid, action, fault_flags, fault_any, hv_runup,
                    now_seconds, read_index, input ready);
    modport sink   (input valid, action, fault_flags, fault_any, hv_runup,
                    now_seconds, read_index, output ready);
endinterface

interface tfs_out_if import tfs_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          send_fault_reset;
    logic                          send_operate;
    logic                          auto_reset_enabled;
    logic [PHASE_W-1:0]            recovery_phase;
    logic                          recovery_failed;
    logic [NUM_FAULTS-1:0]         new_fault_flags;
    logic [READ_COUNT_W-1:0]       read_count;
    logic signed [READ_TIME_W-1:0] read_time;

    modport source (output valid, send_fault_reset, send_operate, auto_reset_enabled,
                    recovery_phase, recovery_failed, new_fault_flags, read_count,
                    read_time, input ready);
    modport sink   (input valid, send_fault_reset, send_operate, auto_reset_enabled,
                    recovery_phase, recovery_failed, new_fault_flags, read_count,
                    read_time, output ready);
endinterface

interface tfs_cfg_if import tfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/tfs_fault_stats.sv
// per-fault edge detection, saturating edge counters and last edge times
// depends on tfs_pkg

module tfs_fault_stats
    import tfs_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stats_req i_req,
    output t_stats_rsp o_rsp
);

    localparam int EXT_W = (COUNT_WIDTH > READ_COUNT_W) ? COUNT_WIDTH : READ_COUNT_W;

    logic [NUM_FAULTS-1:0]  r_prev_flags;
    logic [NUM_FAULTS-1:0]  r_time_seen;
    logic [COUNT_WIDTH-1:0] r_count [NUM_FAULTS];
    logic [TIME_W-1:0]      r_time  [NUM_FAULTS];
    logic [NUM_FAULTS-1:0]  w_rose;
    logic [EXT_W-1:0]       w_count_ext;
    logic                   w_in_range;

    // rising edges against the previous poll
    assign w_rose = i_req.flags & ~r_prev_flags;

    // previous flags, counters and the never-seen marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_flags <= '0;
            r_time_seen  <= '0;
            for (int i = 0; i < NUM_FAULTS; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_req.update) begin
            r_prev_flags <= i_req.flags;
            for (int i = 0; i < NUM_FAULTS; i++) begin
                if (w_rose[i]) begin
                    r_time_seen[i] <= 1'b1;
                    if (r_count[i] != '1) begin
                        r_count[i] <= r_count[i] + 1'b1;
                    end
                end
            end
        end
    end

    // edge times, only meaningful once marked as seen
    always_ff @(posedge i_clk) begin
        if (i_req.update) begin
            for (int i = 0; i < NUM_FAULTS; i++) begin
                if (w_rose[i]) begin
                    r_time[i] <= i_req.now;
                end
            end
        end
    end

    // read port, selected fault or nothing
    assign w_in_range = i_req.read_index < READ_IDX_W'(NUM_FAULTS);

    always_comb begin
        w_count_ext     = '0;
        o_rsp.rose      = w_rose;
        o_rsp.count     = '0;
        o_rsp.last_time = '1;
        if (w_in_range) begin
            w_count_ext = EXT_W'(r_count[i_req.read_index]);
            o_rsp.count = w_count_ext[READ_COUNT_W-1:0];
            if (r_time_seen[i_req.read_index]) begin
                o_rsp.last_time = {1'b0, r_time[i_req.read_index]};
            end
        end
    end

endmodule

>>> rtl/core/transmitter_fault_supervisor_top.sv
// top level of the transmitter fault supervisor: input register, recovery
// state machine, pulse fault history and result register
// depends on tfs_pkg, tfs_if and tfs_fault_stats

// One status item is accepted per clock cycle while the input register is empty
// or can hand its item on; the item waits in the input register and its result
// goes to the output register, and the path between them is a single pass of edge
// detection, one signed subtraction per time check and the recovery state machine.
// While a result waits, an item is taken only into an empty input register.
// Configuration writes are always accepted at once and must only be made while
// no item is in flight. After reset the block needs no clearing pass: fault
// times read as never until their first edge, and the pulse history is only
// compared once it has been filled.

module transmitter_fault_supervisor_top
    import tfs_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfs_in_if.sink    i_in,
    tfs_out_if.source o_out,
    tfs_cfg_if.sink   i_cfg
);

    localparam int HEAD_W = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int DIFF_W = TIME_W + 1;
    localparam int EXT_W  = (COUNT_WIDTH > READ_COUNT_W) ? COUNT_WIDTH : READ_COUNT_W;

    // configuration registers
    logic [WINDOW_W-1:0] r_window;
    logic [RECENT_W-1:0] r_recent;
    logic [TRIES_W-1:0]  r_max_tries;

    // pipeline registers
    logic     r_in_valid;
    t_in_item r_in;
    logic     r_out_valid;
    t_result  r_res;
    t_result  n_res;
    logic     w_adv;

    // supervisor state
    t_phase             r_phase, n_phase;
    logic [TRIES_W-1:0] r_try, n_try;
    logic               r_auto_en, n_auto_en;
    logic [COUNT_WIDTH-1:0] r_auto_cnt, n_auto_cnt;
    logic [TIME_W-1:0]  r_runup_time, n_runup_time;
    logic [TIME_W-1:0]  r_hist [HISTORY_DEPTH];
    logic [HEAD_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               w_hist_we;

    // datapath helpers
    t_stats_req               w_stats_req;
    t_stats_rsp               w_stats_rsp;
    logic [TRIES_W-1:0]       w_limit;
    logic [TRIES_W-1:0]       w_try_inc;
    logic [HEAD_W-1:0]        w_head_next;
    logic [FILL_W-1:0]        w_fill_next;
    logic signed [DIFF_W-1:0] w_age;
    logic signed [DIFF_W-1:0] w_span;
    logic                     w_recent;
    logic                     w_outside_window;
    logic [EXT_W-1:0]         w_auto_ext;

    // configuration port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RST;
            r_recent    <= RECENT_RST;
            r_max_tries <= MAX_TRIES_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WINDOW:    r_window    <= i_cfg.data;
                CFG_RECENT:    r_recent    <= i_cfg.data[RECENT_W-1:0];
                CFG_MAX_TRIES: r_max_tries <= i_cfg.data[TRIES_W-1:0];
                default:       ;
            endcase
        end
    end

    // handshake: input register moves on when the result register is free
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action        <= i_in.action;
            r_in.fault_flags   <= i_in.fault_flags;
            r_in.fault_any     <= i_in.fault_any;
            r_in.hv_runup      <= i_in.hv_runup;
            r_in.now_seconds   <= i_in.now_seconds;
            r_in.read_index    <= i_in.read_index;
        end
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    // fault statistics
    assign w_stats_req.update     = w_adv && (r_in.action == ACT_POLL);
    assign w_stats_req.flags      = r_in.fault_flags;
    assign w_stats_req.now        = r_in.now_seconds;
    assign w_stats_req.read_index = r_in.read_index;

    tfs_fault_stats #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_stats_req),
        .o_rsp   (w_stats_rsp)
    );

    // try limit, zero tries act as one
    assign w_limit   = (r_max_tries == '0) ? TRIES_W'(1) : r_max_tries;
    assign w_try_inc = r_try + 1'b1;

    // runup age uses this poll's runup time
    assign n_runup_time = (r_in.action == ACT_POLL && r_in.hv_runup) ?
                          r_in.now_seconds : r_runup_time;
    assign w_age    = $signed({1'b0, r_in.now_seconds}) - $signed({1'b0, n_runup_time});
    assign w_recent = w_age < $signed(DIFF_W'(r_recent));

    // history ring: oldest entry sits just after the slot being written
    assign w_head_next = (r_head == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_fill_next = (r_fill < FILL_W'(HISTORY_DEPTH)) ? r_fill + 1'b1 : r_fill;
    assign w_span      = $signed({1'b0, r_in.now_seconds}) - $signed({1'b0, r_hist[w_head_next]});
    assign w_outside_window = w_span > $signed(DIFF_W'(r_window));

    assign w_auto_ext = EXT_W'(r_auto_cnt);

    // per-item update and result
    always_comb begin
        n_phase    = r_phase;
        n_try      = r_try;
        n_auto_en  = r_auto_en;
        n_auto_cnt = r_auto_cnt;
        n_head     = r_head;
        n_fill     = r_fill;
        w_hist_we  = 1'b0;

        n_res.send_fault_reset   = 1'b0;
        n_res.send_operate       = 1'b0;
        n_res.recovery_failed    = 1'b0;
        n_res.new_fault_flags    = '0;
        n_res.read_count         = '0;
        n_res.read_time          = '0;
        n_res.auto_reset_enabled = 1'b0;
        n_res.recovery_phase     = PHASE_CODE_IDLE;

        unique case (r_in.action)
            ACT_POLL: begin
                n_res.new_fault_flags = w_stats_rsp.rose;
                unique case (r_phase)
                    PH_CLEAR: begin
                        if (!r_in.fault_any || w_try_inc >= w_limit) begin
                            if (r_in.fault_any) begin
                                n_auto_en             = 1'b0;
                                n_res.recovery_failed = 1'b1;
                            end
                            n_phase            = PH_OPERATE;
                            n_try              = TRIES_W'(1);
                            n_res.send_operate = 1'b1;
                        end else begin
                            n_try = w_try_inc;
                        end
                    end
                    PH_OPERATE: begin
                        if (r_in.hv_runup) begin
                            n_phase = PH_IDLE;
                            n_try   = '0;
                        end else if (r_try >= w_limit) begin
                            n_res.recovery_failed = 1'b1;
                            n_phase               = PH_IDLE;
                            n_try                 = '0;
                        end else begin
                            n_res.send_operate = 1'b1;
                            n_try              = w_try_inc;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (r_auto_en && r_in.fault_flags[PULSE_BIT]) begin
                            w_hist_we = 1'b1;
                            n_head    = w_head_next;
                            n_fill    = w_fill_next;
                            if (w_fill_next == FILL_W'(HISTORY_DEPTH) && !w_outside_window) begin
                                n_auto_en = 1'b0;
                            end else begin
                                n_res.send_fault_reset = 1'b1;
                                if (r_auto_cnt != '1) begin
                                    n_auto_cnt = r_auto_cnt + 1'b1;
                                end
                                if (w_recent) begin
                                    n_phase = PH_CLEAR;
                                    n_try   = '0;
                                end
                            end
                        end
                    end
                endcase
            end
            ACT_MANUAL_RESET: begin
                n_res.send_fault_reset = 1'b1;
                n_auto_en              = 1'b1;
            end
            ACT_READ: begin
                n_res.read_time = '1;
                if (r_in.read_index == AUTO_READ_INDEX) begin
                    n_res.read_count = w_auto_ext[READ_COUNT_W-1:0];
                end else begin
                    n_res.read_count = w_stats_rsp.count;
                    n_res.read_time  = w_stats_rsp.last_time;
                end
            end
            default: ;
        endcase

        // status after the step
        n_res.auto_reset_enabled = n_auto_en;
        n_res.recovery_phase     = phase_code(n_phase);
    end

    // supervisor state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_try        <= '0;
            r_auto_en    <= 1'b1;
            r_auto_cnt   <= '0;
            r_runup_time <= '0;
            r_head       <= '0;
            r_fill       <= '0;
        end else if (w_adv) begin
            r_phase      <= n_phase;
            r_try        <= n_try;
            r_auto_en    <= n_auto_en;
            r_auto_cnt   <= n_auto_cnt;
            r_runup_time <= n_runup_time;
            r_head       <= n_head;
            r_fill       <= n_fill;
        end
    end

    // pulse fault history, written at the head slot
    always_ff @(posedge i_clk) begin
        if (w_adv && w_hist_we) begin
            r_hist[r_head] <= r_in.now_seconds;
        end
    end

    // result channel
    assign o_out.valid              = r_out_valid;
    assign o_out.send_fault_reset   = r_res.send_fault_reset;
    assign o_out.send_operate       = r_res.send_operate;
    assign o_out.auto_reset_enabled = r_res.auto_reset_enabled;
    assign o_out.recovery_phase     = r_res.recovery_phase;
    assign o_out.recovery_failed    = r_res.recovery_failed;
    assign o_out.new_fault_flags    = r_res.new_fault_flags;
    assign o_out.read_count         = r_res.read_count;
    assign o_out.read_time          = r_res.read_time;

`ifndef NO_ASSERTIONS
    // a fault reset and an operate command never go out together
    a_no_reset_with_operate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.send_operate |-> !r_res.send_fault_reset)
        else $error("fault reset and operate in the same result");

    // a recovery failure only comes from a recovery phase, never with a reset
    a_failed_no_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.recovery_failed |-> !r_res.send_fault_reset)
        else $error("recovery failure together with fault reset");

    // entering the clearing phase always comes with a fault reset transfer
    a_clear_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLEAR) && !$past(r_phase == PH_CLEAR) |->
            r_out_valid && r_res.send_fault_reset)
        else $error("clearing phase entered without a fault reset");

    // auto reset can only be switched off by an item being processed
    a_auto_off_by_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_auto_en) |-> $past(w_adv))
        else $error("auto reset disabled without an item");

    // history fill never runs past the ring depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HISTORY_DEPTH))
        else $error("history fill beyond depth");
`endif

endmodule

>>> test/testbench.sv
// self-checking testbench for transmitter_fault_supervisor_top: directed and random
// status traffic, with an in-bench predictor of the supervisor and a result scoreboard
// depends on tfs_pkg, tfs_if and the block's rtl
`timescale 1ns / 1ps

module testbench;
    import tfs_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES   = 4;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_OFF_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tfs_in_if  status_if ();
    tfs_out_if result_if ();
    tfs_cfg_if cfg_if ();

    transmitter_fault_supervisor_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (status_if),
        .o_out   (result_if),
        .i_cfg   (cfg_if)
    );

    // clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [WINDOW_W-1:0] window_cfg = WINDOW_RST;
    logic [RECENT_W-1:0] recent_cfg = RECENT_RST;
    logic [TRIES_W-1:0]  tries_cfg  = MAX_TRIES_RST;

    // predictor copy of the supervisor state
    logic [NUM_FAULTS-1:0]   prev_flags = '0;
    logic [READ_COUNT_W-1:0] fault_count [NUM_FAULTS];
    logic [READ_TIME_W-1:0]  fault_time [NUM_FAULTS];
    logic                    auto_en = 1'b1;
    logic [READ_COUNT_W-1:0] auto_resets = '0;
    logic [TIME_W-1:0]       last_runup = '0;
    logic [TIME_W-1:0]       pulse_times [HISTORY_DEPTH_DEF];
    int                      hist_fill = 0;
    int                      hist_head = 0;
    t_phase                  rec_phase = PH_IDLE;
    logic [TRIES_W-1:0]      tries_used = '0;

    t_result expected_results [$];

    // run bookkeeping
    int          mismatches = 0;
    int          items_sent = 0;
    int          polls_seen = 0;
    int          recoveries_started = 0;
    int          lockouts = 0;
    int          recovery_timeouts = 0;
    int          hold_request = 0;
    bit          steady = 1'b0;
    logic [TIME_W-1:0] poll_time = '0;

    // expected result of one accepted status item, advancing the predictor state
    function automatic t_result predict_status(input t_in_item it);
        t_result r;
        logic [TRIES_W-1:0] limit;
        logic [NUM_FAULTS-1:0] rose;
        longint span;
        longint age;
        bit do_reset;
        int f;
        r = '0;
        limit = (tries_cfg == '0) ? TRIES_W'(1) : tries_cfg;
        case (it.action)
            ACT_POLL: begin
                polls_seen++;
                rose = it.fault_flags & ~prev_flags;
                for (f = 0; f < NUM_FAULTS; f++) begin
                    if (rose[f]) begin
                        if (fault_count[f] != '1) fault_count[f] = fault_count[f] + 1'b1;
                        fault_time[f] = {1'b0, it.now_seconds};
                    end
                end
                prev_flags = it.fault_flags;
                if (it.hv_runup) last_runup = it.now_seconds;
                r.new_fault_flags = rose;
                case (rec_phase)
                    // waiting for the transmitter to clear its faults
                    PH_CLEAR: begin
                        tries_used = tries_used + 1'b1;
                        if (!it.fault_any || tries_used >= limit) begin
                            if (it.fault_any) begin
                                auto_en = 1'b0;
                                r.recovery_failed = 1'b1;
                                recovery_timeouts++;
                            end
                            rec_phase = PH_OPERATE;
                            tries_used = TRIES_W'(1);
                            r.send_operate = 1'b1;
                        end
                    end
                    // resending operate until runup comes back
                    PH_OPERATE: begin
                        if (it.hv_runup) begin
                            rec_phase = PH_IDLE;
                            tries_used = '0;
                        end else if (tries_used >= limit) begin
                            r.recovery_failed = 1'b1;
                            recovery_timeouts++;
                            rec_phase = PH_IDLE;
                            tries_used = '0;
                        end else begin
                            r.send_operate = 1'b1;
                            tries_used = tries_used + 1'b1;
                        end
                    end
                    // idle: pulse fault goes into the history ring
                    default: begin
                        rec_phase = PH_IDLE;
                        if (auto_en && it.fault_flags[PULSE_BIT]) begin
                            pulse_times[hist_head] = it.now_seconds;
                            hist_head = (hist_head + 1) % HISTORY_DEPTH_DEF;
                            if (hist_fill < HISTORY_DEPTH_DEF) hist_fill++;
                            if (hist_fill < HISTORY_DEPTH_DEF) begin
                                do_reset = 1'b1;
                            end else begin
                                span = longint'(it.now_seconds) - longint'(pulse_times[hist_head]);
                                do_reset = span > longint'(window_cfg);
                            end
                            if (!do_reset) begin
                                auto_en = 1'b0;
                                lockouts++;
                            end else begin
                                r.send_fault_reset = 1'b1;
                                if (auto_resets != '1) auto_resets = auto_resets + 1'b1;
                                age = longint'(it.now_seconds) - longint'(last_runup);
                                if (age < longint'(recent_cfg)) begin
                                    rec_phase = PH_CLEAR;
                                    tries_used = '0;
                                    recoveries_started++;
                                end
                            end
                        end
                    end
                endcase
            end
            ACT_MANUAL_RESET: begin
                r.send_fault_reset = 1'b1;
                auto_en = 1'b1;
            end
            ACT_READ: begin
                r.read_time = '1;
                if (it.read_index < NUM_FAULTS) begin
                    r.read_count = fault_count[it.read_index];
                    r.read_time  = fault_time[it.read_index];
                end else if (it.read_index == AUTO_READ_INDEX) begin
                    r.read_count = auto_resets;
                end
            end
            default: ;
        endcase
        r.auto_reset_enabled = auto_en;
        case (rec_phase)
            PH_CLEAR:   r.recovery_phase = PHASE_CODE_CLEAR;
            PH_OPERATE: r.recovery_phase = PHASE_CODE_OPERATE;
            default:    r.recovery_phase = PHASE_CODE_IDLE;
        endcase
        return r;
    endfunction

    function automatic t_in_item make_status(input logic [ACTION_W-1:0] action,
                                             input logic [NUM_FAULTS-1:0] flags,
                                             input logic summary, input logic runup,
                                             input logic [TIME_W-1:0] now,
                                             input logic [READ_IDX_W-1:0] idx);
        t_in_item it;
        it.action        = action;
        it.fault_flags   = flags;
        it.fault_any     = summary;
        it.hv_runup      = runup;
        it.now_seconds   = now;
        it.read_index    = idx;
        return it;
    endfunction

    // random status item: mostly polls with slowly rising time, some jumps and reads
    function automatic t_in_item random_status();
        t_in_item it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)      poll_time = poll_time + TIME_W'($urandom_range(0, 3));
        else if (pick < 88) poll_time = poll_time + TIME_W'($urandom_range(4, 150));
        else if (pick < 94) poll_time = poll_time - TIME_W'($urandom_range(1, 200));
        else                poll_time = TIME_W'($urandom);
        it.fault_flags = NUM_FAULTS'($urandom);
        it.fault_flags[PULSE_BIT] = ($urandom_range(0, 9) < 6);
        it.fault_any = (it.fault_flags != '0) ? ($urandom_range(0, 3) != 0)
                                              : ($urandom_range(0, 3) == 0);
        it.hv_runup    = 1'($urandom_range(0, 1));
        it.now_seconds = poll_time;
        it.read_index  = READ_IDX_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 8)       it.action = ACT_READ;
        else if (pick < 12) it.action = ACT_MANUAL_RESET;
        else if (pick < 14) it.action = ACT_UNUSED;
        else                it.action = ACT_POLL;
        return it;
    endfunction

    // offer one status item, after a random gap unless in steady mode, and log its expected result
    task automatic send_status(input t_in_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            status_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        status_if.valid         <= 1'b1;
        status_if.action        <= it.action;
        status_if.fault_flags   <= it.fault_flags;
        status_if.fault_any     <= it.fault_any;
        status_if.hv_runup      <= it.hv_runup;
        status_if.now_seconds   <= it.now_seconds;
        status_if.read_index    <= it.read_index;
        do @(posedge i_clk); while (!status_if.ready);
        expected_results.insert(expected_results.size(), predict_status(it));
        items_sent++;
    endtask

    // write all three registers once the block has drained
    task automatic write_config(input logic [WINDOW_W-1:0] window,
                                input logic [RECENT_W-1:0] recent,
                                input logic [TRIES_W-1:0] tries);
        logic [CFG_DATA_W-1:0] vals [3];
        logic [CFG_IDX_W-1:0]  idxs [3];
        int k;
        vals = '{CFG_DATA_W'(window), CFG_DATA_W'(recent), CFG_DATA_W'(tries)};
        idxs = '{CFG_WINDOW, CFG_RECENT, CFG_MAX_TRIES};
        status_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        for (k = 0; k < 3; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idxs[k];
            cfg_if.data  <= vals[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            case (idxs[k])
                CFG_WINDOW:    window_cfg = vals[k][WINDOW_W-1:0];
                CFG_RECENT:    recent_cfg = vals[k][RECENT_W-1:0];
                CFG_MAX_TRIES: tries_cfg  = vals[k][TRIES_W-1:0];
                default: ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    // counters and times straight after reset, out-of-range index, unused action
    task automatic test_reset_reads();
        send_status(make_status(ACT_READ, '0, 1'b0, 1'b0, '0, 4'd0));
        send_status(make_status(ACT_READ, '1, 1'b1, 1'b1, '1, 4'd8));
        send_status(make_status(ACT_READ, '0, 1'b0, 1'b0, '0, AUTO_READ_INDEX));
        send_status(make_status(ACT_READ, '0, 1'b0, 1'b0, '0, 4'd15));
        send_status(make_status(ACT_UNUSED, '1, 1'b1, 1'b1, '1, 4'd15));
    endtask

    // rising edges of every flag, at the extremes of time
    task automatic test_fault_edges();
        send_status(make_status(ACT_POLL, '1, 1'b1, 1'b0, '1, 4'd0));
        send_status(make_status(ACT_POLL, '0, 1'b0, 1'b0, '0, 4'd0));
        send_status(make_status(ACT_POLL, '1, 1'b1, 1'b0, 31'd3, 4'd0));
        send_status(make_status(ACT_READ, '0, 1'b0, 1'b0, '0, 4'd4));
        send_status(make_status(ACT_READ, '0, 1'b0, 1'b0, '0, AUTO_READ_INDEX));
    endtask

    // clearing timeout then operate timeout, then a manual reset
    task automatic test_recovery_timeouts();
        logic [NUM_FAULTS-1:0] pulse;
        pulse = '0;
        pulse[PULSE_BIT] = 1'b1;
        write_config(16'd100, 8'd255, 4'd2);
        send_status(make_status(ACT_POLL, pulse, 1'b1, 1'b1, 31'd1000, 4'd0));
        send_status(make_status(ACT_POLL, pulse, 1'b1, 1'b0, 31'd1001, 4'd0));
        send_status(make_status(ACT_POLL, pulse, 1'b1, 1'b0, 31'd1002, 4'd0));
        send_status(make_status(ACT_POLL, '0, 1'b0, 1'b0, 31'd1003, 4'd0));
        send_status(make_status(ACT_POLL, '0, 1'b0, 1'b0, 31'd1004, 4'd0));
        send_status(make_status(ACT_MANUAL_RESET, '0, 1'b0, 1'b0, '0, 4'd0));
    endtask

    // backwards runup age counts as recent, manual reset mid recovery, zero tries
    task automatic test_recovery_clearing();
        logic [NUM_FAULTS-1:0] pulse;
        pulse = '0;
        pulse[PULSE_BIT] = 1'b1;
        write_config(16'd0, 8'd0, 4'd0);
        send_status(make_status(ACT_POLL, '0, 1'b0, 1'b1, 31'd2000, 4'd0));
        send_status(make_status(ACT_POLL, pulse, 1'b1, 1'b0, 31'd1500, 4'd0));
        send_status(make_status(ACT_MANUAL_RESET, '0, 1'b0, 1'b0, '0, 4'd0));
        send_status(make_status(ACT_POLL, '0, 1'b0, 1'b0, 31'd1501, 4'd0));
        send_status(make_status(ACT_POLL, '0, 1'b0, 1'b1, 31'd1502, 4'd0));
    endtask

    task automatic test_random_traffic(input int count, input bit no_gaps);
        int n;
        steady = no_gaps;
        for (n = 0; n < count; n++) send_status(random_status());
        steady = 1'b0;
    endtask

    // long receiver hold-off while the sender keeps offering back to back
    task automatic test_backpressure(input int count);
        int n;
        steady = 1'b1;
        hold_request = HOLD_OFF_CYCLES;
        for (n = 0; n < count; n++) send_status(random_status());
        steady = 1'b0;
    endtask

    // result receiver with random stalls and the odd long hold-off
    initial begin : result_sink
        int stall;
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else if (steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 6);
            end
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk); while (!result_if.valid);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no expectation outstanding");
                mismatches++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                check_field("send_fault_reset", 32'(want.send_fault_reset),
                            32'(result_if.send_fault_reset));
                check_field("send_operate", 32'(want.send_operate),
                            32'(result_if.send_operate));
                check_field("auto_reset_enabled", 32'(want.auto_reset_enabled),
                            32'(result_if.auto_reset_enabled));
                check_field("recovery_phase", 32'(want.recovery_phase),
                            32'(result_if.recovery_phase));
                check_field("recovery_failed", 32'(want.recovery_failed),
                            32'(result_if.recovery_failed));
                check_field("new_fault_flags", 32'(want.new_fault_flags),
                            32'(result_if.new_fault_flags));
                check_field("read_count", 32'(want.read_count), 32'(result_if.read_count));
                check_field("read_time", want.read_time, result_if.read_time);
            end
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((status_if.valid && status_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   quiet_cycles, expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // main sequence
    initial begin : main_seq
        int f;
        for (f = 0; f < NUM_FAULTS; f++) begin
            fault_count[f] = '0;
            fault_time[f]  = '1;
        end
        i_rst_n                 <= 1'b0;
        status_if.valid         <= 1'b0;
        status_if.action        <= ACT_POLL;
        status_if.fault_flags   <= '0;
        status_if.fault_any     <= 1'b0;
        status_if.hv_runup      <= 1'b0;
        status_if.now_seconds   <= '0;
        status_if.read_index    <= '0;
        cfg_if.valid            <= 1'b0;
        cfg_if.index            <= CFG_WINDOW;
        cfg_if.data             <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_reads();
        test_fault_edges();
        test_recovery_timeouts();
        test_recovery_clearing();

        write_config(WINDOW_RST, RECENT_RST, MAX_TRIES_RST);
        test_random_traffic(120, 1'b0);
        write_config(16'hFFFF, 8'hFF, 4'hF);
        test_random_traffic(100, 1'b0);
        write_config(16'd0, 8'd0, 4'd1);
        test_random_traffic(100, 1'b0);
        write_config(WINDOW_W'($urandom_range(0, 400)), RECENT_W'($urandom_range(0, 10)),
                     TRIES_W'($urandom_range(1, 15)));
        test_random_traffic(100, 1'b1);
        test_backpressure(30);
        write_config(16'd30, 8'd5, 4'd3);
        test_random_traffic(80, 1'b0);

        // drain, then allow for the output register
        status_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);

        $display("covered %0d status items (%0d polls), %0d recoveries started,",
                 items_sent, polls_seen, recoveries_started);
        $display("%0d auto reset lockouts, %0d recovery timeouts, %0d mismatches",
                 lockouts, recovery_timeouts, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tfs_pkg.sv
rtl/core/tfs_if.sv
rtl/core/tfs_fault_stats.sv
rtl/core/transmitter_fault_supervisor_top.sv
test/testbench.sv
